/* src/eti_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eti_pkg: shared types and constants of the escape-time fractal iterator
// Payload structs, register indexes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package eti_pkg;

  localparam int COORD_W   = 10;
  localparam int COUNT_W   = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CFG_IDX_W = 3;
  localparam int ESC_RADIUS_SQ = 16;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COUNT_W-1:0] iteration_count;
    logic               inside_set;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RE_START        = 3'd0,
    REG_RE_STEP         = 3'd1,
    REG_IM_START        = 3'd2,
    REG_IM_STEP         = 3'd3,
    REG_JULIA_RE        = 3'd4,
    REG_JULIA_IM        = 3'd5,
    REG_MAX_ITER        = 3'd6,
    REG_MANDELBROT_MODE = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_MAP_Y,
    ST_LOAD,
    ST_TEST,
    ST_MUL_BB,
    ST_MUL_AB,
    ST_UPDATE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_MAP_X,
    DP_MAP_Y,
    DP_LOAD,
    DP_MUL_AA,
    DP_MUL_BB,
    DP_MUL_AB,
    DP_UPDATE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   finish;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escaped;
  } dp_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[DATA_W-1:0]);
    end
    return r;
  endfunction

endpackage

/* src/eti_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eti_ctrl: iteration sequencer
// Steps the datapath through mapping, squaring and update, and pulses done.
// ----------------------------------------------------------------------------
module eti_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  eti_pkg::dp_status_t status,
  output eti_pkg::dp_cmd_t    cmd
);
  import eti_pkg::*;

  ctrl_state_t state, state_next;
  logic        done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = DP_CAPTURE;
          state_next = ST_MAP_X;
        end
      end
      ST_MAP_X: begin
        cmd.op     = DP_MAP_X;
        state_next = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        cmd.op     = DP_MAP_Y;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.op     = DP_LOAD;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        // limit first: no escape test once the count has reached max_iter
        if (status.limit_hit) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.op     = DP_MUL_AA;
          state_next = ST_MUL_BB;
        end
      end
      ST_MUL_BB: begin
        cmd.op     = DP_MUL_BB;
        state_next = ST_MUL_AB;
      end
      ST_MUL_AB: begin
        cmd.op     = DP_MUL_AB;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.escaped) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.op     = DP_UPDATE;
          state_next = ST_TEST;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign done_next = cmd.finish;
  assign busy      = (state != ST_IDLE);

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_MAP_X))
    else $error("accepted transfer did not start mapping");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_busy_falls_with_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("sequencer went idle without a result");

  a_no_update_past_limit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_MUL_AA) |-> !status.limit_hit)
    else $error("iteration started at the limit");

endmodule

/* src/eti_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eti_dp: fixed-point datapath
// Configuration registers, one shared 32x32 multiplier and the z update.
// ----------------------------------------------------------------------------
module eti_dp #(
  parameter int FRAC_BITS = 26
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [eti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [eti_pkg::DATA_W-1:0]      cfg_data,
  input  eti_pkg::pixel_t                 pixel,
  input  eti_pkg::dp_cmd_t                cmd,
  output eti_pkg::dp_status_t             status,
  output eti_pkg::result_t                result
);
  import eti_pkg::*;

  localparam logic [PROD_W-1:0] ESC_HI = PROD_W'(ESC_RADIUS_SQ) << FRAC_BITS;

  logic signed [DATA_W-1:0]  re_start, re_step, im_start, im_step;
  logic signed [DATA_W-1:0]  julia_re, julia_im;
  logic [COUNT_W-1:0]        max_iter;
  logic                      mandelbrot_mode;

  pixel_t                    pix;
  logic signed [DATA_W-1:0]  za, zb, c_re, c_im;
  logic signed [PROD_W-1:0]  p0, p1, p2, diff;
  logic [PROD_W-1:0]         sum;
  logic [COUNT_W-1:0]        count;

  logic signed [DATA_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DATA_W-1:0]  start_re, start_im;
  logic [PROD_W-1:0]         sum_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      re_start        <= -(DATA_W'(1) <<< FRAC_BITS);
      re_step         <= 32'sd131072;
      im_start        <= -(DATA_W'(1) <<< FRAC_BITS);
      im_step         <= 32'sd131072;
      julia_re        <= '0;
      julia_im        <= '0;
      max_iter        <= 16'd64;
      mandelbrot_mode <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RE_START:        re_start        <= $signed(cfg_data);
        REG_RE_STEP:         re_step         <= $signed(cfg_data);
        REG_IM_START:        im_start        <= $signed(cfg_data);
        REG_IM_STEP:         im_step         <= $signed(cfg_data);
        REG_JULIA_RE:        julia_re        <= $signed(cfg_data);
        REG_JULIA_IM:        julia_im        <= $signed(cfg_data);
        REG_MAX_ITER:        max_iter        <= cfg_data[COUNT_W-1:0];
        REG_MANDELBROT_MODE: mandelbrot_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = za;
    mul_b = zb;
    case (cmd.op)
      DP_MAP_X: begin
        mul_a = $signed({{(DATA_W-COORD_W){1'b0}}, pix.pixel_x});
        mul_b = re_step;
      end
      DP_MAP_Y: begin
        mul_a = $signed({{(DATA_W-COORD_W){1'b0}}, pix.pixel_y});
        mul_b = im_step;
      end
      DP_MUL_AA: begin
        mul_a = za;
        mul_b = za;
      end
      DP_MUL_BB: begin
        mul_a = zb;
        mul_b = zb;
      end
      default: begin
        mul_a = za;
        mul_b = zb;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign start_re = sat32(PROD_W'(re_start) + p0);
  assign start_im = sat32(PROD_W'(im_start) + p1);

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      DP_CAPTURE: pix <= pixel;
      DP_MAP_X, DP_MUL_AA: p0 <= prod;
      DP_MAP_Y, DP_MUL_BB: p1 <= prod;
      DP_MUL_AB: begin
        p2   <= prod;
        sum  <= unsigned'(p0) + unsigned'(p1);
        diff <= p0 - p1;
      end
      DP_LOAD: begin
        za   <= start_re;
        zb   <= start_im;
        c_re <= mandelbrot_mode ? start_re : julia_re;
        c_im <= mandelbrot_mode ? start_im : julia_im;
      end
      DP_UPDATE: begin
        za <= sat32((diff >>> FRAC_BITS) + PROD_W'(c_re));
        zb <= sat32((p2 >>> (FRAC_BITS - 1)) + PROD_W'(c_im));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.op == DP_CAPTURE) begin
      count <= '0;
    end else if (cmd.op == DP_UPDATE) begin
      count <= count + COUNT_W'(1);
    end
  end

  // strictly greater than 16 in squared magnitude
  assign sum_hi           = sum >> FRAC_BITS;
  assign status.escaped   = (sum_hi > ESC_HI) ||
                            ((sum_hi == ESC_HI) && (sum[FRAC_BITS-1:0] != '0));
  assign status.limit_hit = (count == max_iter);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.out_x           <= pix.pixel_x;
      result.out_y           <= pix.pixel_y;
      result.iteration_count <= count;
      result.inside_set      <= status.limit_hit;
    end
  end

endmodule

/* src/escape_time_fractal_iterator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator: Mandelbrot / Julia escape-time iteration
// Maps a pixel to a Q6.26 start point and iterates z = z^2 + c to escape or the limit.
// ----------------------------------------------------------------------------
// channel  | signals                             | transfer when
// ---------+-------------------------------------+------------------------
// pixel in | start, busy, pixel                  | start && !busy
// result   | done, result                        | done (one cycle)
// config   | cfg_write, cfg_index, cfg_data      | cfg_write
//
// One pixel is in flight at a time; busy stays high until its result.
// Each update runs a*a, b*b and a*b in turn through the shared 32x32
// multiplier, then adds and saturates.
// Reset is synchronous and restores the default view. The result is shown
// for the single cycle of done and busy is already low in that cycle.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator #(
  parameter int FRAC_BITS = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  eti_pkg::pixel_t               pixel,
  output logic                          done,
  output eti_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [eti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eti_pkg::DATA_W-1:0]    cfg_data
);
  import eti_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  eti_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .cmd    (cmd)
  );

  eti_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

/* tb/escape_count_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_count_checker: predicts and checks escape-time results
// Watches the pixel, result and register channels of the fractal iterator,
// keeps its own copy of the view registers, works out the iteration count of
// every pixel transfer and compares each result against the oldest one owed.
// ----------------------------------------------------------------------------
module escape_count_checker #(
  parameter int FRAC_BITS = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  eti_pkg::pixel_t               pixel,
  input  logic                          done,
  input  eti_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [eti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eti_pkg::DATA_W-1:0]    cfg_data,
  output int                            mismatch_total,
  output int                            results_owed
);
  import eti_pkg::*;

  // |z|^2 bound of 16 at the scale of an exact square
  localparam logic [63:0] ESCAPE_BOUND = 64'd16 << (2 * FRAC_BITS);

  logic signed [31:0] view_re0, view_dre, view_im0, view_dim, seed_re, seed_im;
  logic [15:0]        iter_limit;
  logic               mandel_sel;
  result_t            owed_q[$];
  result_t            want;
  int                 fails;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] == {33{v[63]}}) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  function automatic result_t predict_escape(input pixel_t p);
    logic signed [63:0] col, row, base, step, za, zb, ca, cb, aa, bb, ab;
    logic signed [31:0] re, im;
    logic [63:0]        mag;
    logic               gone;
    int unsigned        n;
    result_t            r;
    col  = {54'd0, p.pixel_x};
    row  = {54'd0, p.pixel_y};
    base = view_re0;
    step = view_dre;
    re   = clamp32(base + col * step);
    base = view_im0;
    step = view_dim;
    im   = clamp32(base + row * step);
    if (mandel_sel) begin
      ca = re;
      cb = im;
    end else begin
      ca = seed_re;
      cb = seed_im;
    end
    n    = 0;
    gone = 1'b0;
    // test before every update; a point leaving on the last update stays inside
    while (n < iter_limit && !gone) begin
      za  = re;
      zb  = im;
      aa  = za * za;
      bb  = zb * zb;
      mag = aa + bb;
      if (mag > ESCAPE_BOUND) begin
        gone = 1'b1;
      end else begin
        ab = za * zb;
        re = clamp32(((aa - bb) >>> FRAC_BITS) + ca);
        im = clamp32((ab >>> (FRAC_BITS - 1)) + cb);
        n++;
      end
    end
    r.out_x           = p.pixel_x;
    r.out_y           = p.pixel_y;
    r.iteration_count = 16'(n);
    r.inside_set      = (n == iter_limit);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      view_re0   = -32'sd67108864;
      view_dre   = 32'sd131072;
      view_im0   = -32'sd67108864;
      view_dim   = 32'sd131072;
      seed_re    = '0;
      seed_im    = '0;
      iter_limit = 16'd64;
      mandel_sel = 1'b1;
      owed_q.delete();
      fails = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RE_START:        view_re0   = cfg_data;
          REG_RE_STEP:         view_dre   = cfg_data;
          REG_IM_START:        view_im0   = cfg_data;
          REG_IM_STEP:         view_dim   = cfg_data;
          REG_JULIA_RE:        seed_re    = cfg_data;
          REG_JULIA_IM:        seed_im    = cfg_data;
          REG_MAX_ITER:        iter_limit = cfg_data[15:0];
          REG_MANDELBROT_MODE: mandel_sel = cfg_data[0];
          default: ;
        endcase
      end
      // retire the finished pixel before booking a new one from the same edge
      if (done) begin
        if (owed_q.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("unexpected result: x %0d y %0d count %0d inside %0d",
                     result.out_x, result.out_y, result.iteration_count,
                     result.inside_set);
          end
        end else begin
          want = owed_q.pop_front();
          if (result.out_x != want.out_x || result.out_y != want.out_y ||
              result.iteration_count != want.iteration_count ||
              result.inside_set != want.inside_set) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: expected x %0d y %0d count %0d inside %0d, got x %0d y %0d count %0d inside %0d",
                       want.out_x, want.out_y, want.iteration_count, want.inside_set,
                       result.out_x, result.out_y, result.iteration_count,
                       result.inside_set);
            end
          end
        end
      end
      if (start && !busy) begin
        owed_q.push_back(predict_escape(pixel));
      end
    end
    mismatch_total <= fails;
    results_owed   <= owed_q.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the escape-time fractal iterator
// Drives directed corner pixels and views, then blocks of random views and
// pixels under changing sender gaps; the checker beside the block scores it.
// ----------------------------------------------------------------------------
module testbench;
  import eti_pkg::*;

  localparam int STALL_LIMIT      = 1_000_000;
  localparam int RANDOM_BLOCKS    = 14;
  localparam int PIXELS_PER_BLOCK = 104;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 cfg_write = 1'b0;
  pixel_t               pixel     = '0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;
  logic                 busy;
  logic                 done;
  result_t              result;
  int                   mismatch_total;
  int                   results_owed;
  int                   gap_pct      = 0;
  int                   stall_cycles = 0;

  escape_time_fractal_iterator dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  escape_count_checker count_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .pixel          (pixel),
    .done           (done),
    .result         (result),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    start         <= 1'b1;
    pixel.pixel_x <= x;
    pixel.pixel_y <= y;
    do @(posedge clk); while (busy);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic load_view(input logic [31:0] re0, input logic [31:0] dre,
                           input logic [31:0] im0, input logic [31:0] dim,
                           input logic [31:0] jre, input logic [31:0] jim,
                           input logic [31:0] lim, input logic [31:0] mode);
    drain();
    write_reg(REG_RE_START, re0);
    write_reg(REG_RE_STEP, dre);
    write_reg(REG_IM_START, im0);
    write_reg(REG_IM_STEP, dim);
    write_reg(REG_JULIA_RE, jre);
    write_reg(REG_JULIA_IM, jim);
    write_reg(REG_MAX_ITER, lim);
    write_reg(REG_MANDELBROT_MODE, mode);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] pick_extreme();
    logic [31:0] v;
    case ($urandom_range(4))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic load_random_view();
    int          kind;
    int          lim;
    logic [31:0] f [6];
    logic [31:0] lim_word;
    logic [31:0] mode_word;
    kind = $urandom_range(9);
    if (kind == 0) begin
      foreach (f[i]) f[i] = $urandom;
      lim = $urandom_range(40);
    end else if (kind == 1) begin
      foreach (f[i]) f[i] = pick_extreme();
      case ($urandom_range(2))
        0:       lim = 0;
        1:       lim = 1;
        default: lim = $urandom_range(2, 30);
      endcase
    end else begin
      // view over the interesting part of the plane, Q6.26
      f[0] = $urandom_range(201326592) - 167772160;
      f[1] = $urandom_range(1, 400000);
      if ($urandom_range(3) == 0) f[1] = -f[1];
      f[2] = $urandom_range(201326592) - 100663296;
      f[3] = $urandom_range(1, 400000);
      if ($urandom_range(3) == 0) f[3] = -f[3];
      f[4] = $urandom_range(134217728) - 67108864;
      f[5] = $urandom_range(134217728) - 67108864;
      lim  = ($urandom_range(7) == 0) ? $urandom_range(49, 200) : $urandom_range(1, 48);
    end
    // upper data bits are don't-care for the narrow registers
    lim_word        = $urandom;
    lim_word[15:0]  = 16'(lim);
    mode_word       = $urandom;
    load_view(f[0], f[1], f[2], f[3], f[4], f[5], lim_word, mode_word);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset view: -1.0 up to just under +1.0, limit 64, Mandelbrot
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd768, 10'd512);

    // zero limit
    load_view(-32'sd67108864, 32'd131072, -32'sd67108864, 32'd131072,
              32'd0, 32'd0, 32'd0, 32'd1);
    send_pixel(10'd300, 10'd700);
    send_pixel(10'd1023, 10'd0);

    // z0 = 3.0 passes the first test and leaves on the only update
    load_view(32'd201326592, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
    send_pixel(10'd5, 10'd5);
    load_view(32'd201326592, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2, 32'd1);
    send_pixel(10'd5, 10'd5);

    // start point saturates at the coordinate extremes
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd0, 32'd0, 32'hFFFF, 32'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd2, 10'd1);
    send_pixel(10'd1023, 10'd0);

    // Julia constant at full scale drives the update into saturation
    load_view(32'd261724570, 32'd0, -32'sd20000000, 32'd0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'd10, 32'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);

    // origin never escapes: full 16-bit limit
    load_view(32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'hFFFF, 32'd1);
    send_pixel(10'd0, 10'd0);

    // classic Julia view
    load_view(-32'sd134217728, 32'd262144, -32'sd134217728, 32'd262144,
              -32'sd53687091, 32'd10468982, 32'd100, 32'd0);
    send_pixel(10'd511, 10'd600);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd700, 10'd300);

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      gap_pct = (blk < 5) ? 25 : (blk < 10) ? 55 : 0;
      load_random_view();
      repeat (PIXELS_PER_BLOCK) begin
        send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/eti_pkg.sv
src/eti_ctrl.sv
src/eti_dp.sv
src/escape_time_fractal_iterator.sv
tb/escape_count_checker.sv
tb/testbench.sv
